/* hdl/cpg_pkg.sv */
// Shared types and constants for the client pool grant block.
package cpg_pkg;

	localparam int TAG_W      = 8;
	localparam int CLIENT_W   = 3;
	localparam int MASK_W     = 8;
	localparam int MAXW_W     = 5;
	localparam int NUM_CLIENTS = 8;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [MAXW_W-1:0] MAXW_RESET = MAXW_W'(16);

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		OC_GRANTED  = 3'd0,
		OC_QUEUED   = 3'd1,
		OC_REJECTED = 3'd2,
		OC_HANDED   = 3'd3,
		OC_IDLE     = 3'd4
	} outcome_t;

	typedef enum logic {
		REG_MAX_WAITING = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic             push;
		logic             pop;
		logic [TAG_W-1:0] tag;
	} queue_cmd_t;

endpackage

/* hdl/cpg_regs.sv */
// APB configuration register holding the wait queue limit.
module cpg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpg_pkg::PADDR_W-1:0]   paddr,
	input  logic [cpg_pkg::PDATA_W-1:0]   pwdata,
	output logic [cpg_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [cpg_pkg::MAXW_W-1:0]    max_waiting
);
	import cpg_pkg::*;

	logic [MAXW_W-1:0] max_waiting_q;
	logic              wr_en;
	reg_idx_t          reg_idx;

	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);
	assign wr_en   = psel && penable && pwrite && (reg_idx == REG_MAX_WAITING);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_waiting_q <= MAXW_RESET;
		end else if (wr_en) begin
			max_waiting_q <= pwdata[MAXW_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_MAX_WAITING: prdata = PDATA_W'(max_waiting_q);
			default:         prdata = '0;
		endcase
	end

	assign max_waiting = max_waiting_q;

endmodule

/* hdl/cpg_queue.sv */
// Circular wait queue of requester tags with a registered head read.
module cpg_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cpg_pkg::queue_cmd_t       cmd,
	output logic [CNT_W-1:0]          count,
	output logic [cpg_pkg::TAG_W-1:0] head_tag
);
	import cpg_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

	logic [TAG_W-1:0] mem [QUEUE_DEPTH];
	logic [PW-1:0]    head_q, tail_q, head_nxt, tail_nxt;
	logic [CNT_W-1:0] count_q;
	logic [TAG_W-1:0] head_tag_q;

	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		if (cmd.pop) begin
			head_nxt = (head_q == LAST) ? '0 : head_q + PW'(1);
		end
		if (cmd.push) begin
			tail_nxt = (tail_q == LAST) ? '0 : tail_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_nxt;
			tail_q <= tail_nxt;
			if (cmd.push && !cmd.pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop && !cmd.push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= cmd.tag;
		end
		if (cmd.push && (tail_q == head_nxt)) begin
			head_tag_q <= cmd.tag;
		end else begin
			head_tag_q <= mem[head_nxt];
		end
	end

	assign count    = count_q;
	assign head_tag = head_tag_q;

endmodule

/* hdl/client_pool_grant_with_wait_queue_top.sv */
// Client pool grant block with a FIFO wait queue: top level.
// One request per cycle: an accepted request is held in an input register and its result
// is then registered in the result register, and the sustained rate is one request per
// clock while out_ready stays high. The decision is a combinational priority encode over
// the ready vector plus one push or pop of the wait queue, whose head entry is kept in a
// register read from the queue memory ahead of time. in_ready is high whenever the input
// register is empty or moves forward; a stalled result holds the input register, and
// in_ready then drops. max_waiting sits at byte address 0 of the APB port and resets to
// 16; it must only be written while no request is in flight.
module client_pool_grant_with_wait_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [cpg_pkg::PADDR_W-1:0]      paddr,
	input  logic [cpg_pkg::PDATA_W-1:0]      pwdata,
	output logic [cpg_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             op,
	input  logic [cpg_pkg::TAG_W-1:0]        request_tag,
	input  logic [cpg_pkg::MASK_W-1:0]       ready_mask,
	input  logic [cpg_pkg::CLIENT_W-1:0]     released_client,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       outcome,
	output logic [cpg_pkg::CLIENT_W-1:0]     granted_client,
	output logic [cpg_pkg::TAG_W-1:0]        granted_tag
);
	import cpg_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > MAXW_W) ? CNT_W : MAXW_W;
	localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(QUEUE_DEPTH);
	localparam int USED = (NUM_CLIENTS < MASK_W) ? NUM_CLIENTS : MASK_W;

	logic [MAXW_W-1:0]   max_waiting;
	queue_cmd_t          qcmd;
	logic [CNT_W-1:0]    q_count;
	logic [TAG_W-1:0]    q_head_tag;

	logic                valid_s1;
	op_t                 op_s1;
	logic [TAG_W-1:0]    tag_s1;
	logic [MASK_W-1:0]   mask_s1;
	logic [CLIENT_W-1:0] rel_s1;

	logic                out_valid_q;
	outcome_t            outcome_q;
	logic [CLIENT_W-1:0] client_q;
	logic [TAG_W-1:0]    gtag_q;

	logic                advance;
	logic                full;
	logic                found;
	logic [CLIENT_W-1:0] pick;
	outcome_t            oc_d;
	logic [CLIENT_W-1:0] client_d;
	logic [TAG_W-1:0]    gtag_d;

	cpg_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.max_waiting (max_waiting)
	);

	cpg_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (qcmd),
		.count    (q_count),
		.head_tag (q_head_tag)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// capture request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op_t'(op);
			tag_s1  <= request_tag;
			mask_s1 <= ready_mask;
			rel_s1  <= released_client;
		end
	end

	// lowest ready client
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = USED - 1; i >= 0; i--) begin
			if (mask_s1[i]) begin
				found = 1'b1;
				pick  = CLIENT_W'(i);
			end
		end
	end

	assign full = (CMP_W'(q_count) >= CMP_W'(max_waiting)) || (CMP_W'(q_count) >= DEPTH_CMP);

	always_comb begin
		oc_d      = OC_IDLE;
		client_d  = '0;
		gtag_d    = '0;
		qcmd.push = 1'b0;
		qcmd.pop  = 1'b0;
		qcmd.tag  = tag_s1;
		unique case (op_s1)
			OP_REQUEST: begin
				if (full) begin
					oc_d = OC_REJECTED;
				end else if (found) begin
					oc_d     = OC_GRANTED;
					client_d = pick;
					gtag_d   = tag_s1;
				end else begin
					oc_d      = OC_QUEUED;
					qcmd.push = advance;
				end
			end
			OP_RELEASE: begin
				if (q_count == '0) begin
					oc_d = OC_IDLE;
				end else begin
					oc_d     = OC_HANDED;
					client_d = rel_s1;
					gtag_d   = q_head_tag;
					qcmd.pop = advance;
				end
			end
			default: oc_d = OC_IDLE;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome_q <= oc_d;
			client_q  <= client_d;
			gtag_q    <= gtag_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign outcome        = outcome_q;
	assign granted_client = client_q;
	assign granted_tag    = gtag_q;

endmodule

/* hdl/cpg_checker.sv */
// Port-level checks for the client pool grant block, bound to the top level.
module cpg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [2:0]                   outcome,
	input logic [cpg_pkg::CLIENT_W-1:0] granted_client,
	input logic [cpg_pkg::TAG_W-1:0]    granted_tag
);
	import cpg_pkg::*;

	a_reset_clears: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_outcome_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome == OC_GRANTED || outcome == OC_QUEUED ||
			outcome == OC_REJECTED || outcome == OC_HANDED || outcome == OC_IDLE))
		else $error("outcome code out of range");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (outcome == OC_QUEUED || outcome == OC_REJECTED ||
			outcome == OC_IDLE)) |-> (granted_client == '0 && granted_tag == '0))
		else $error("grant fields set without a grant");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(outcome) &&
			$stable(granted_client) && $stable(granted_tag)))
		else $error("stalled result changed");

endmodule

bind client_pool_grant_with_wait_queue_top cpg_checker u_cpg_checker (.*);
